/* hw/rtl/rccf_pkg.sv */
// shared widths, codes and default sizes for the canonical scaling block
package rccf_pkg;

  localparam int REQ_W = 2;
  localparam int ROW_W = 7;
  localparam int COL_W = 8;
  localparam int VAL_W = 8;

  localparam int ROWS_CFG_W = 8;
  localparam int COLS_CFG_W = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  localparam int DEF_MAX_ROWS      = 128;
  localparam int DEF_MAX_COLS      = 256;
  localparam int DEF_FIELD_MODULUS = 127;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 8'd128;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 9'd256;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

endpackage

/* hw/rtl/rccf_req_if.sv */
// request and response channel interfaces
interface rccf_req_if import rccf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [VAL_W-1:0] value;
  modport source (output valid, req_type, row, col, value, input ready);
  modport sink (input valid, req_type, row, col, value, output ready);
endinterface

interface rccf_rsp_if import rccf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

/* hw/rtl/rccf_ram.sv */
// generic single port ram with registered read
module rccf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hw/rtl/rccf_mulmod.sv */
// pipelined modular multiplier, reciprocal reduction
module rccf_mulmod import rccf_pkg::*; #(
  parameter int FIELD_MODULUS = DEF_FIELD_MODULUS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic             done,
  output logic [VAL_W-1:0] y
);
  localparam int PW    = 2 * VAL_W;
  localparam int SHIFT = 24;
  localparam int RECIP = (1 << SHIFT) / FIELD_MODULUS;
  localparam logic [SHIFT-1:0] RECIP_C = SHIFT'(RECIP);
  localparam logic [VAL_W-1:0] MOD_C   = VAL_W'(FIELD_MODULUS);

  logic [3:0]          vld;
  logic [PW-1:0]       p1, p2, p3;
  logic [PW-1:0]       q2, qm3;
  logic [SHIFT+PW-1:0] t;
  logic [PW+VAL_W-1:0] qm_full;
  logic [PW-1:0]       r;

  assign t       = p1 * RECIP_C;
  assign qm_full = q2 * MOD_C;
  assign r       = p3 - qm3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], go};
    end
  end

  always_ff @(posedge clk) begin
    p1  <= a * b;
    p2  <= p1;
    q2  <= t[SHIFT +: PW];
    p3  <= p2;
    qm3 <= qm_full[PW-1:0];
    // estimate is low by at most one modulus
    if (r >= PW'(FIELD_MODULUS)) begin
      y <= VAL_W'(r - PW'(FIELD_MODULUS));
    end else begin
      y <= VAL_W'(r);
    end
  end

  assign done = vld[3];
endmodule

/* hw/rtl/row_column_scaling_canonical_form_unit.sv */
// top level of the row and column scaling canonical form unit
//
// usage: requests arrive on the req channel (valid/ready), one result per
// request leaves on the rsp channel. req_type write stores value mod the
// field modulus into the matrix ram, read returns the stored entry (zero
// outside the store), run brings the top-left rows_in_use x cols_in_use part
// into canonical scaled form. every other request answers zero.
// one request is worked at a time; ready is high only while idle.
// a run starts with a clearing pass that sets every scale in use to one and
// untouched, then a root search over the rows, then a walk that gives each
// newly reached row or column its scale (an inverse by square and multiply
// through the 4 stage multiplier), then a final scaling pass over every
// entry in use. all products go through the one shared multiplier, and the
// matrix ram has a single port.
// the result sits in an output register; when the receiver stalls the next
// request is still taken and only its result waits for the register.
// reset (synchronous, active high) clears control state and loads the size
// registers with their defaults; matrix contents are undefined until
// written. config writes go through cfg_write_en/cfg_index.
module row_column_scaling_canonical_form_unit import rccf_pkg::*; #(
  parameter int MAX_ROWS      = DEF_MAX_ROWS,
  parameter int MAX_COLS      = DEF_MAX_COLS,
  parameter int FIELD_MODULUS = DEF_FIELD_MODULUS
) (
  input  logic                  clk,
  input  logic                  rst,
  rccf_req_if.sink              req,
  rccf_rsp_if.source            rsp,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int NRW = RW + 1;
  localparam int NCW = CW + 1;
  localparam int CLW = (NRW > NCW) ? NRW : NCW;
  // scale entry: touched flag on top of the scale
  localparam int SCW = VAL_W + 1;
  localparam int ST_W = 6;

  localparam logic [ST_W-1:0] S_IDLE = 6'd0, S_WR = 6'd1, S_RD = 6'd2, S_RD2 = 6'd3,
    S_DONE = 6'd4, S_RUN_INIT = 6'd5, S_ROOT = 6'd6, S_RSCAN = 6'd7, S_RSCAN_CHK = 6'd8,
    S_ROOT_SET = 6'd9, S_WALK = 6'd10, S_RQ = 6'd11, S_RQ2 = 6'd12, S_RQ3 = 6'd13,
    S_RROW = 6'd14, S_RROW_CHK = 6'd15, S_RROW_INV = 6'd16, S_RROW_SET = 6'd17,
    S_RROW_NXT = 6'd18, S_CQ = 6'd19, S_CQ2 = 6'd20, S_CQ3 = 6'd21, S_CCOL = 6'd22,
    S_CCOL_CHK = 6'd23, S_CCOL_INV = 6'd24, S_CCOL_SET = 6'd25, S_CCOL_NXT = 6'd26,
    S_INV0 = 6'd27, S_INV = 6'd28, S_INV_A = 6'd29, S_INV_B = 6'd30, S_MUL = 6'd31,
    S_FIN_INIT = 6'd32, S_FIN_RD = 6'd33, S_FIN_D = 6'd34, S_FIN_M2 = 6'd35,
    S_FIN_WR = 6'd36, S_CLR = 6'd37, S_ROOT_CHK = 6'd38;

  // control
  logic [ST_W-1:0] state, ret_state, inv_ret;
  logic            rsp_valid;
  logic [VAL_W-1:0] rsp_data, res;

  // size registers
  logic [ROWS_CFG_W-1:0] rows_in_use;
  logic [COLS_CFG_W-1:0] cols_in_use;
  logic [NRW-1:0]        nr, nr_next;
  logic [NCW-1:0]        nc, nc_next;

  // captured request
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             in_range_r;

  // walk state
  logic [CLW-1:0]      clr;
  logic [NRW-1:0]      root, ri, rh, rtl;
  logic [NCW-1:0]      ci, ch, ctl;
  logic [RW-1:0]       cur_r;
  logic [CW-1:0]       cur_c;
  logic [VAL_W-1:0]    scl, col_scl;
  logic                col_phase;

  // multiplier and inverse
  logic             mm_go, mm_done;
  logic [VAL_W-1:0] op_a, op_b, mm_y, mres;
  logic [VAL_W-1:0] inv_acc, inv_base, inv_e;

  // memories
  logic [RW+CW-1:0] mat_addr;
  logic             mat_we;
  logic [VAL_W-1:0] mat_wd, mat_rd;
  logic [RW-1:0]    rsc_addr, rq_addr, rq_wd, rq_rd;
  logic             rsc_we, rq_we;
  logic [SCW-1:0]   rsc_wd, rsc_rd;
  logic [CW-1:0]    csc_addr, cq_addr, cq_wd, cq_rd;
  logic             csc_we, cq_we;
  logic [SCW-1:0]   csc_wd, csc_rd;
  logic [RW-1:0]    mat_row;
  logic [CW-1:0]    mat_col;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.read_value = rsp_data;

  // clamp the size registers into 1..max
  always_comb begin
    if (rows_in_use == '0) begin
      nr_next = NRW'(1);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      nr_next = NRW'(MAX_ROWS);
    end else begin
      nr_next = NRW'(rows_in_use);
    end
    if (cols_in_use == '0) begin
      nc_next = NCW'(1);
    end else if (int'(cols_in_use) > MAX_COLS) begin
      nc_next = NCW'(MAX_COLS);
    end else begin
      nc_next = NCW'(cols_in_use);
    end
  end

  // memory port steering
  always_comb begin
    mat_row  = cur_r;
    mat_col  = cur_c;
    mat_we   = 1'b0;
    mat_wd   = mres;
    rsc_addr = ri[RW-1:0];
    rsc_we   = 1'b0;
    rsc_wd   = {1'b1, inv_acc};
    csc_addr = ci[CW-1:0];
    csc_we   = 1'b0;
    csc_wd   = {1'b1, inv_acc};
    rq_addr  = rh[RW-1:0];
    rq_we    = 1'b0;
    rq_wd    = ri[RW-1:0];
    cq_addr  = ch[CW-1:0];
    cq_we    = 1'b0;
    cq_wd    = ci[CW-1:0];
    case (state)
      S_WR: begin
        mat_row = RW'(row_r);
        mat_col = CW'(col_r);
        mat_we  = in_range_r;
      end
      S_RD: begin
        mat_row = RW'(row_r);
        mat_col = CW'(col_r);
      end
      S_CLR: begin
        // every scale in use back to one, untouched
        rsc_addr = clr[RW-1:0];
        rsc_we   = (clr < CLW'(nr));
        rsc_wd   = {1'b0, VAL_W'(1)};
        csc_addr = clr[CW-1:0];
        csc_we   = (clr < CLW'(nc));
        csc_wd   = {1'b0, VAL_W'(1)};
      end
      S_ROOT: rsc_addr = root[RW-1:0];
      S_RSCAN: begin
        mat_row = root[RW-1:0];
        mat_col = ci[CW-1:0];
      end
      S_ROOT_SET: begin
        // a root row keeps scale one
        rsc_addr = root[RW-1:0];
        rsc_we   = 1'b1;
        rsc_wd   = {1'b1, VAL_W'(1)};
        rq_addr  = '0;
        rq_we    = 1'b1;
        rq_wd    = root[RW-1:0];
      end
      S_RQ2: rsc_addr = rq_rd;
      S_RROW: mat_col = ci[CW-1:0];
      S_RROW_SET: begin
        csc_we  = 1'b1;
        cq_addr = ctl[CW-1:0];
        cq_we   = 1'b1;
      end
      S_CQ2: csc_addr = cq_rd;
      S_CCOL: mat_row = ri[RW-1:0];
      S_CCOL_SET: begin
        rsc_we  = 1'b1;
        rq_addr = rtl[RW-1:0];
        rq_we   = 1'b1;
      end
      S_FIN_RD: begin
        mat_row = ri[RW-1:0];
        mat_col = ci[CW-1:0];
      end
      S_FIN_WR: begin
        mat_row = ri[RW-1:0];
        mat_col = ci[CW-1:0];
        mat_we  = 1'b1;
      end
      default: ;
    endcase
    mat_addr = {mat_row, mat_col};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      mm_go       <= 1'b0;
      col_phase   <= 1'b0;
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else begin
      mm_go <= 1'b0;
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_ROWS: rows_in_use <= cfg_data[ROWS_CFG_W-1:0];
          CFG_COLS: cols_in_use <= cfg_data[COLS_CFG_W-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            row_r      <= req.row;
            col_r      <= req.col;
            in_range_r <= (int'(req.row) < MAX_ROWS) && (int'(req.col) < MAX_COLS);
            res        <= '0;
            unique case (req.req_type)
              REQ_WRITE: begin
                // reduce the written value through the multiplier
                op_a      <= req.value;
                op_b      <= VAL_W'(1);
                mm_go     <= 1'b1;
                ret_state <= S_WR;
                state     <= S_MUL;
              end
              REQ_READ: state <= S_RD;
              REQ_RUN:  state <= S_RUN_INIT;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_WR: state <= S_DONE;
        S_RD: state <= S_RD2;
        S_RD2: begin
          res   <= in_range_r ? mat_rd : '0;
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_data  <= res;
            state     <= S_IDLE;
          end
        end

        S_RUN_INIT: begin
          nr    <= nr_next;
          nc    <= nc_next;
          clr   <= '0;
          root  <= '0;
          state <= S_CLR;
        end
        S_CLR: begin
          if ((clr + 1'b1 >= CLW'(nr)) && (clr + 1'b1 >= CLW'(nc))) begin
            state <= S_ROOT;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        S_ROOT: begin
          if (root == nr) begin
            state <= S_FIN_INIT;
          end else begin
            state <= S_ROOT_CHK;
          end
        end
        S_ROOT_CHK: begin
          // rows reached by an earlier walk are no roots
          if (rsc_rd[VAL_W]) begin
            root  <= root + 1'b1;
            state <= S_ROOT;
          end else begin
            ci    <= '0;
            state <= S_RSCAN;
          end
        end
        S_RSCAN: state <= S_RSCAN_CHK;
        S_RSCAN_CHK: begin
          // first nonzero entry makes this row a root
          if (mat_rd != '0) begin
            state <= S_ROOT_SET;
          end else if (ci + 1'b1 == nc) begin
            root  <= root + 1'b1;
            state <= S_ROOT;
          end else begin
            ci    <= ci + 1'b1;
            state <= S_RSCAN;
          end
        end
        S_ROOT_SET: begin
          rh        <= '0;
          rtl       <= NRW'(1);
          ch        <= '0;
          ctl       <= '0;
          col_phase <= 1'b0;
          state     <= S_WALK;
        end
        S_WALK: begin
          // drain all queued rows, then all queued columns, until both queues are empty
          if (!col_phase) begin
            if (rh != rtl) begin
              state <= S_RQ;
            end else begin
              col_phase <= 1'b1;
            end
          end else if (ch != ctl) begin
            state <= S_CQ;
          end else if (rh != rtl) begin
            col_phase <= 1'b0;
          end else begin
            root  <= root + 1'b1;
            state <= S_ROOT;
          end
        end

        // row side of the walk
        S_RQ: begin
          rh    <= rh + 1'b1;
          state <= S_RQ2;
        end
        S_RQ2: begin
          cur_r <= rq_rd;
          state <= S_RQ3;
        end
        S_RQ3: begin
          scl   <= rsc_rd[VAL_W-1:0];
          ci    <= '0;
          state <= S_RROW;
        end
        S_RROW: state <= S_RROW_CHK;
        S_RROW_CHK: begin
          if (mat_rd != '0 && !csc_rd[VAL_W]) begin
            op_a      <= scl;
            op_b      <= mat_rd;
            mm_go     <= 1'b1;
            ret_state <= S_RROW_INV;
            state     <= S_MUL;
          end else begin
            state <= S_RROW_NXT;
          end
        end
        S_RROW_INV: begin
          inv_ret <= S_RROW_SET;
          state   <= S_INV0;
        end
        S_RROW_SET: begin
          ctl   <= ctl + 1'b1;
          state <= S_RROW_NXT;
        end
        S_RROW_NXT: begin
          if (ci + 1'b1 == nc) begin
            state <= S_WALK;
          end else begin
            ci    <= ci + 1'b1;
            state <= S_RROW;
          end
        end

        // column side of the walk
        S_CQ: begin
          ch    <= ch + 1'b1;
          state <= S_CQ2;
        end
        S_CQ2: begin
          cur_c <= cq_rd;
          state <= S_CQ3;
        end
        S_CQ3: begin
          scl   <= csc_rd[VAL_W-1:0];
          ri    <= '0;
          state <= S_CCOL;
        end
        S_CCOL: state <= S_CCOL_CHK;
        S_CCOL_CHK: begin
          if (mat_rd != '0 && !rsc_rd[VAL_W]) begin
            op_a      <= mat_rd;
            op_b      <= scl;
            mm_go     <= 1'b1;
            ret_state <= S_CCOL_INV;
            state     <= S_MUL;
          end else begin
            state <= S_CCOL_NXT;
          end
        end
        S_CCOL_INV: begin
          inv_ret <= S_CCOL_SET;
          state   <= S_INV0;
        end
        S_CCOL_SET: begin
          rtl   <= rtl + 1'b1;
          state <= S_CCOL_NXT;
        end
        S_CCOL_NXT: begin
          if (ri + 1'b1 == nr) begin
            state <= S_WALK;
          end else begin
            ri    <= ri + 1'b1;
            state <= S_CCOL;
          end
        end

        // inverse as mres^(modulus-2), square and multiply
        S_INV0: begin
          inv_acc  <= VAL_W'(1);
          inv_base <= mres;
          inv_e    <= VAL_W'(FIELD_MODULUS - 2);
          state    <= S_INV;
        end
        S_INV: begin
          if (inv_e == '0) begin
            state <= inv_ret;
          end else if (inv_e[0]) begin
            op_a      <= inv_acc;
            op_b      <= inv_base;
            mm_go     <= 1'b1;
            ret_state <= S_INV_A;
            state     <= S_MUL;
          end else begin
            op_a      <= inv_base;
            op_b      <= inv_base;
            mm_go     <= 1'b1;
            ret_state <= S_INV_B;
            state     <= S_MUL;
          end
        end
        S_INV_A: begin
          inv_acc   <= mres;
          op_a      <= inv_base;
          op_b      <= inv_base;
          mm_go     <= 1'b1;
          ret_state <= S_INV_B;
          state     <= S_MUL;
        end
        S_INV_B: begin
          inv_base <= mres;
          inv_e    <= inv_e >> 1;
          state    <= S_INV;
        end
        S_MUL: begin
          if (mm_done) begin
            mres  <= mm_y;
            state <= ret_state;
          end
        end

        // final pass: entry times row scale times column scale
        S_FIN_INIT: begin
          ri    <= '0;
          ci    <= '0;
          state <= S_FIN_RD;
        end
        S_FIN_RD: state <= S_FIN_D;
        S_FIN_D: begin
          // untouched lines still hold scale one from the clearing pass
          op_a      <= mat_rd;
          op_b      <= rsc_rd[VAL_W-1:0];
          col_scl   <= csc_rd[VAL_W-1:0];
          mm_go     <= 1'b1;
          ret_state <= S_FIN_M2;
          state     <= S_MUL;
        end
        S_FIN_M2: begin
          op_a      <= mres;
          op_b      <= col_scl;
          mm_go     <= 1'b1;
          ret_state <= S_FIN_WR;
          state     <= S_MUL;
        end
        S_FIN_WR: begin
          if (ci + 1'b1 == nc) begin
            ci <= '0;
            if (ri + 1'b1 == nr) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              ri    <= ri + 1'b1;
              state <= S_FIN_RD;
            end
          end else begin
            ci    <= ci + 1'b1;
            state <= S_FIN_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rccf_mulmod #(.FIELD_MODULUS(FIELD_MODULUS)) u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .go   (mm_go),
    .a    (op_a),
    .b    (op_b),
    .done (mm_done),
    .y    (mm_y)
  );

  rccf_ram #(.WIDTH(VAL_W), .DEPTH(1 << (RW + CW))) u_matrix (
    .clk (clk), .addr (mat_addr), .we (mat_we), .wdata (mat_wd), .rdata (mat_rd)
  );

  rccf_ram #(.WIDTH(SCW), .DEPTH(1 << RW)) u_row_scale (
    .clk (clk), .addr (rsc_addr), .we (rsc_we), .wdata (rsc_wd), .rdata (rsc_rd)
  );

  rccf_ram #(.WIDTH(SCW), .DEPTH(1 << CW)) u_col_scale (
    .clk (clk), .addr (csc_addr), .we (csc_we), .wdata (csc_wd), .rdata (csc_rd)
  );

  rccf_ram #(.WIDTH(RW), .DEPTH(1 << RW)) u_row_queue (
    .clk (clk), .addr (rq_addr), .we (rq_we), .wdata (rq_wd), .rdata (rq_rd)
  );

  rccf_ram #(.WIDTH(CW), .DEPTH(1 << CW)) u_col_queue (
    .clk (clk), .addr (cq_addr), .we (cq_we), .wdata (cq_wd), .rdata (cq_rd)
  );

endmodule

/* tb/sv/row_column_scaling_canonical_form_unit_tb.sv */
// testbench for the row and column scaling canonical form unit
module row_column_scaling_canonical_form_unit_tb;
  import rccf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS = DEF_MAX_ROWS;
  localparam int NCOLS = DEF_MAX_COLS;
  localparam int PMOD  = DEF_FIELD_MODULUS;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_GOAL = 700;
  // request code with no meaning to the block, answered with zero
  localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

  typedef struct {
    logic [REQ_W-1:0] kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    bit               fixed;
    logic [VAL_W-1:0] want;
  } stim_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rccf_req_if req_ch ();
  rccf_rsp_if rsp_ch ();

  row_column_scaling_canonical_form_unit uut (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // shadow of the matrix, the size registers and which entries hold data
  bit [7:0] mat [NROWS][NCOLS];
  bit written [NROWS][NCOLS];
  int written_keys[$];
  int rows_cfg;
  int cols_cfg;

  logic [VAL_W-1:0] read_values_due[$];
  int mismatches;
  int sent_items;
  int cycles;

  // receiver pacing: long hold set by the sender side, short per-result gaps
  int hold_left;
  int rsp_gap;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int fmul(int a, int b);
    return (a * b) % PMOD;
  endfunction

  // inverse as x^(p-2), which is 0 for x = 0
  function automatic int finv(int x);
    int acc;
    int base;
    int e;
    acc = 1 % PMOD;
    base = x % PMOD;
    e = PMOD - 2;
    while (e != 0) begin
      if (e & 1) acc = fmul(acc, base);
      base = fmul(base, base);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic int clamp_size(int v, int top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // breadth-first walk that fixes row and column scales, then scales the part in use
  function automatic void scale_to_canonical();
    int nr;
    int nc;
    int rs [NROWS];
    int cs [NCOLS];
    bit rdone [NROWS];
    bit cdone [NCOLS];
    int rq [NROWS];
    int cq [NCOLS];
    int rh, rt, ch, ct, rr, cc;
    bit any;
    nr = clamp_size(rows_cfg, NROWS);
    nc = clamp_size(cols_cfg, NCOLS);
    foreach (rs[i]) begin
      rs[i] = 1;
      rdone[i] = 0;
    end
    foreach (cs[i]) begin
      cs[i] = 1;
      cdone[i] = 0;
    end
    for (int root = 0; root < nr; root++) begin
      if (rdone[root]) continue;
      any = 0;
      for (int c = 0; c < nc; c++) if (mat[root][c] != 0) any = 1;
      if (!any) continue;
      rh = 0; rt = 0; ch = 0; ct = 0;
      rs[root] = 1;
      rdone[root] = 1;
      rq[rt++] = root;
      while (rh < rt || ch < ct) begin
        while (rh < rt) begin
          rr = rq[rh++];
          for (int c = 0; c < nc; c++) begin
            if (mat[rr][c] != 0 && !cdone[c] && ct < NCOLS) begin
              cs[c] = finv(fmul(rs[rr], mat[rr][c]));
              cdone[c] = 1;
              cq[ct++] = c;
            end
          end
        end
        while (ch < ct) begin
          cc = cq[ch++];
          for (int r = 0; r < nr; r++) begin
            if (mat[r][cc] != 0 && !rdone[r] && rt < NROWS) begin
              rs[r] = finv(fmul(mat[r][cc], cs[cc]));
              rdone[r] = 1;
              rq[rt++] = r;
            end
          end
        end
      end
    end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        mat[r][c] = 8'(fmul(fmul(mat[r][c], rs[r]), cs[c]));
  endfunction

  // applies one request to the shadow and returns the read value it gives
  function automatic logic [VAL_W-1:0] apply_request(logic [REQ_W-1:0] kind,
      int r, int c, int v);
    logic [VAL_W-1:0] res;
    res = '0;
    case (kind)
      REQ_WRITE: begin
        mat[r][c] = 8'(v % PMOD);
        if (!written[r][c]) begin
          written[r][c] = 1;
          written_keys.push_back(r * NCOLS + c);
        end
      end
      REQ_RUN: scale_to_canonical();
      REQ_READ: res = mat[r][c];
      default: res = '0;
    endcase
    return res;
  endfunction

  // one request on the input channel, with a random gap after it unless calm
  task automatic send_request(logic [REQ_W-1:0] kind, int r, int c, int v,
      bit fixed = 0, logic [VAL_W-1:0] want = '0);
    logic [VAL_W-1:0] predicted;
    int gap;
    @(negedge clk);
    req_ch.req_type = kind;
    req_ch.row = ROW_W'(r);
    req_ch.col = COL_W'(c);
    req_ch.value = VAL_W'(v);
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_request(kind, r, c, v);
    read_values_due.push_back(fixed ? want : predicted);
    sent_items++;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // waits with valid low until every result is back
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (read_values_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(data);
    if (idx == CFG_ROWS) rows_cfg = data & 8'hFF;
    else cols_cfg = data & 9'h1FF;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  function automatic int draw_value(int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
    return $urandom_range(1, PMOD - 1);
  endfunction

  // one configuration phase: fill the part in use, some noise, a run, read-back
  task automatic scaling_phase(int rcfg, int ccfg, int noise, int long_hold);
    int nr;
    int nc;
    int zero_pct;
    int key;
    int pick;
    drain();
    write_size(CFG_ROWS, rcfg);
    write_size(CFG_COLS, ccfg);
    nr = clamp_size(rows_cfg, NROWS);
    nc = clamp_size(cols_cfg, NCOLS);
    zero_pct = $urandom_range(20, 80);
    calm = ($urandom_range(0, 3) == 0);
    // the receiver stops for a long time while requests keep coming
    if (long_hold) hold_left = 400;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (!written[r][c] || $urandom_range(0, 3) == 0)
          send_request(REQ_WRITE, r, c, draw_value(zero_pct));
    for (int k = 0; k < noise; k++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: send_request(REQ_NOP, $urandom_range(0, NROWS - 1),
                        $urandom_range(0, NCOLS - 1), $urandom_range(0, 255));
        1, 2: send_request(REQ_WRITE, $urandom_range(0, NROWS - 1),
                           $urandom_range(0, NCOLS - 1), $urandom_range(0, 255));
        default: begin
          key = written_keys[$urandom_range(0, written_keys.size() - 1)];
          send_request(REQ_READ, key / NCOLS, key % NCOLS, $urandom_range(0, 255));
        end
      endcase
    end
    send_request(REQ_RUN, $urandom_range(0, NROWS - 1),
                 $urandom_range(0, NCOLS - 1), $urandom_range(0, 255));
    if (nr * nc <= 64) begin
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++)
          send_request(REQ_READ, r, c, $urandom_range(0, 255));
    end else begin
      repeat (16)
        send_request(REQ_READ, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                     $urandom_range(0, 255));
    end
  endtask

  // directed requests; fixed rows carry a result that needs no predictor
  stim_t directed [16] = '{
    '{REQ_WRITE, 7'd0,   8'd0,   8'd3,   1'b1, 8'd0},
    '{REQ_WRITE, 7'd0,   8'd1,   8'd5,   1'b1, 8'd0},
    '{REQ_WRITE, 7'd1,   8'd0,   8'd0,   1'b1, 8'd0},
    '{REQ_WRITE, 7'd1,   8'd1,   8'd7,   1'b1, 8'd0},
    '{REQ_WRITE, 7'd127, 8'd255, 8'd255, 1'b1, 8'd0},
    '{REQ_READ,  7'd127, 8'd255, 8'd0,   1'b1, 8'd1},
    '{REQ_WRITE, 7'd5,   8'd5,   8'd127, 1'b1, 8'd0},
    '{REQ_READ,  7'd5,   8'd5,   8'd255, 1'b1, 8'd0},
    '{REQ_WRITE, 7'd64,  8'd128, 8'd126, 1'b1, 8'd0},
    '{REQ_READ,  7'd64,  8'd128, 8'd0,   1'b1, 8'd126},
    '{REQ_NOP,   7'd127, 8'd255, 8'd255, 1'b1, 8'd0},
    '{REQ_RUN,   7'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{REQ_READ,  7'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{REQ_READ,  7'd0,   8'd1,   8'd0,   1'b0, 8'd0},
    '{REQ_READ,  7'd1,   8'd1,   8'd0,   1'b0, 8'd0},
    '{REQ_READ,  7'd127, 8'd255, 8'd0,   1'b1, 8'd1}
  };

  // receiver: ready changes at the falling edge only
  initial begin
    rsp_ch.ready = 1'b0;
    rsp_gap = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready = 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (read_values_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: read_value %0d", rsp_ch.read_value);
      end else begin
        if (rsp_ch.read_value !== read_values_due[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read_value mismatch: expected %0d got %0d",
                     read_values_due[0], rsp_ch.read_value);
        end
        void'(read_values_due.pop_front());
      end
      rsp_gap = calm ? 0 : $urandom_range(0, 3);
    end
  end

  initial begin
    mismatches = 0;
    sent_items = 0;
    calm = 0;
    rows_cfg = ROWS_RESET;
    cols_cfg = COLS_RESET;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = CFG_ROWS;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_WRITE;
    req_ch.row = '0;
    req_ch.col = '0;
    req_ch.value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // small part in use for the directed run
    write_size(CFG_ROWS, 2);
    write_size(CFG_COLS, 2);
    foreach (directed[i])
      send_request(directed[i].kind, directed[i].row, directed[i].col,
                   directed[i].value, directed[i].fixed, directed[i].want);

    // size extremes, zero and oversize values included
    scaling_phase(0, 0, 4, 0);
    scaling_phase(128, 1, 4, 0);
    scaling_phase(1, 256, 4, 1);
    scaling_phase(255, 0, 4, 0);
    scaling_phase(0, 511, 4, 0);

    while (sent_items < ITEM_GOAL)
      scaling_phase($urandom_range(1, 6), $urandom_range(1, 8),
                    $urandom_range(0, 12), $urandom_range(0, 15) == 0);

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (read_values_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rccf_pkg.sv
hw/rtl/rccf_req_if.sv
hw/rtl/rccf_ram.sv
hw/rtl/rccf_mulmod.sv
hw/rtl/row_column_scaling_canonical_form_unit.sv
tb/sv/row_column_scaling_canonical_form_unit_tb.sv
